// ===== rtl/rotation_matrix_to_quaternion_defines.svh =====
// Assertion macros shared by the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rmq assertion failed");
`define RMQ_ASSERT_NORST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("rmq assertion failed");
`else
`define RMQ_ASSERT(lbl, prop)
`define RMQ_ASSERT_NORST(lbl, prop)
`endif
`endif

// ===== rtl/rmq_pkg.sv =====
// Types and constants for the rotation matrix to quaternion block.
`default_nettype none
package rmq_pkg;
   // Data width of every matrix entry and quaternion part.
   localparam int DW  = 16;
   localparam int FW  = DW - 2;
   localparam int RW  = DW + 1;
   localparam int DDW = DW + 1;
   localparam int SQW = 2 * DW;
   localparam int NW  = 2 * DW + 1;
   localparam int QDEPTH = 4;
   localparam int QAW = 2;

   localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef enum logic [1:0] {
      SLOT_X = 2'd0,
      SLOT_Y = 2'd1,
      SLOT_Z = 2'd2,
      SLOT_W = 2'd3
   } rmq_slot_type;

   typedef struct packed {
      logic signed [DW-1:0] m00;
      logic signed [DW-1:0] m01;
      logic signed [DW-1:0] m02;
      logic signed [DW-1:0] m10;
      logic signed [DW-1:0] m11;
      logic signed [DW-1:0] m12;
      logic signed [DW-1:0] m20;
      logic signed [DW-1:0] m21;
      logic signed [DW-1:0] m22;
   } rmq_req_type;

   typedef struct packed {
      logic signed [DW-1:0] quat_x;
      logic signed [DW-1:0] quat_y;
      logic signed [DW-1:0] quat_z;
      logic signed [DW-1:0] quat_w;
      logic                 degenerate;
   } rmq_rsp_type;

   // Classified item: radicand, the three off-diagonal terms in ascending
   // slot order (skipping the diagonal slot), and the diagonal slot.
   typedef struct packed {
      logic [RW-1:0]         rad;
      logic signed [DDW-1:0] d_a;
      logic signed [DDW-1:0] d_b;
      logic signed [DDW-1:0] d_c;
      rmq_slot_type          diag;
      logic                  degen;
   } rmq_task_type;

   typedef struct packed {
      logic [SQW-1:0]        v;
      logic [SQW-1:0]        res;
      logic signed [DDW-1:0] d_a;
      logic signed [DDW-1:0] d_b;
      logic signed [DDW-1:0] d_c;
      rmq_slot_type          diag;
      logic                  degen;
   } rmq_sq_type;

   typedef struct packed {
      logic [2:0][NW-1:0]   rem;
      logic [2:0][DW-2:0]   q;
      logic [2:0]           neg;
      logic [2:0]           ovf;
      logic [NW-1:0]        den;
      logic signed [DW-1:0] diag_val;
      rmq_slot_type         diag;
      logic                 degen;
   } rmq_div_type;
endpackage
`default_nettype wire

// ===== rtl/rmq_front.sv =====
// Front end: accepts a matrix, picks the branch and axis, forms the radicand.
`default_nettype none
module rmq_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire rmq_pkg::rmq_req_type req_payload,
   output      logic                 task_valid,
   output      rmq_pkg::rmq_task_type task_data,
   input  wire logic                 task_full
);
   import rmq_pkg::*;

   localparam int TW = DW + 3;
   localparam logic signed [TW-1:0] RAD_ONE = TW'(1) <<< FW;

   logic                 front_valid_ff;
   rmq_task_type         front_data_ff;
   rmq_task_type         class_in;
   logic                 advance;
   logic signed [TW-1:0] e00, e11, e22, trace, rad_full;

   // Sign-extended diagonal and trace.
   assign e00   = TW'(req_payload.m00);
   assign e11   = TW'(req_payload.m11);
   assign e22   = TW'(req_payload.m22);
   assign trace = e00 + e11 + e22;

   // Classification of the item.
   always_comb begin
      class_in = '0;
      if (trace > 0) begin
         class_in.diag = SLOT_W;
         rad_full = trace + RAD_ONE;
         class_in.d_a = DDW'(req_payload.m21) - DDW'(req_payload.m12);
         class_in.d_b = DDW'(req_payload.m02) - DDW'(req_payload.m20);
         class_in.d_c = DDW'(req_payload.m10) - DDW'(req_payload.m01);
      end else if ((req_payload.m00 < req_payload.m11) ?
                   (req_payload.m11 < req_payload.m22) :
                   (req_payload.m00 < req_payload.m22)) begin
         class_in.diag = SLOT_Z;
         rad_full = e22 - e00 - e11 + RAD_ONE;
         class_in.d_a = DDW'(req_payload.m02) + DDW'(req_payload.m20);
         class_in.d_b = DDW'(req_payload.m12) + DDW'(req_payload.m21);
         class_in.d_c = DDW'(req_payload.m10) - DDW'(req_payload.m01);
      end else if (req_payload.m00 < req_payload.m11) begin
         class_in.diag = SLOT_Y;
         rad_full = e11 - e22 - e00 + RAD_ONE;
         class_in.d_a = DDW'(req_payload.m01) + DDW'(req_payload.m10);
         class_in.d_b = DDW'(req_payload.m21) + DDW'(req_payload.m12);
         class_in.d_c = DDW'(req_payload.m02) - DDW'(req_payload.m20);
      end else begin
         class_in.diag = SLOT_X;
         rad_full = e00 - e11 - e22 + RAD_ONE;
         class_in.d_a = DDW'(req_payload.m10) + DDW'(req_payload.m01);
         class_in.d_b = DDW'(req_payload.m20) + DDW'(req_payload.m02);
         class_in.d_c = DDW'(req_payload.m21) - DDW'(req_payload.m12);
      end
      // A radicand at or below zero is clamped to the smallest step.
      if (rad_full <= 0) begin
         class_in.rad   = RW'(1);
         class_in.degen = 1'b1;
      end else begin
         class_in.rad   = rad_full[RW-1:0];
         class_in.degen = 1'b0;
      end
   end

   // Front register moves on whenever the queue can take its item.
   assign advance    = !front_valid_ff || !task_full;
   assign req_stall  = !advance;
   assign task_valid = front_valid_ff;
   assign task_data  = front_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (advance) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         front_data_ff <= class_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/rmq_queue.sv =====
// Short item queue between the front end and the arithmetic back end.
`default_nettype none
module rmq_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire rmq_pkg::rmq_task_type push_data,
   output      logic                  full,
   input  wire logic                  pop,
   output      logic                  empty,
   output      rmq_pkg::rmq_task_type head_data
);
   import rmq_pkg::*;
`include "rotation_matrix_to_quaternion_defines.svh"

   rmq_task_type   slots_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QAW:0]   count_ff;
   logic           push, do_pop;

   assign full      = (count_ff == (QAW+1)'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign push      = push_valid && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slots_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RMQ_ASSERT(a_count_range, count_ff <= (QAW+1)'(QDEPTH))
   `RMQ_ASSERT(a_count_up, (push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
   `RMQ_ASSERT(a_ptr_gap, (wr_ptr_ff - rd_ptr_ff) == count_ff[QAW-1:0])
endmodule
`default_nettype wire

// ===== rtl/rmq_back.sv =====
// Back end: pipelined square root, three pipelined dividers, result register.
`default_nettype none
module rmq_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire rmq_pkg::rmq_task_type item_data,
   output      logic                  pop,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rmq_pkg::rmq_rsp_type  rsp_payload
);
   import rmq_pkg::*;
`include "rotation_matrix_to_quaternion_defines.svh"

   logic          en;
   logic [DW:0]   sq_valid_ff;
   rmq_sq_type    sq_ff [DW+1];
   rmq_sq_type    sq_in [DW+1];
   logic [DW-1:0] dv_valid_ff;
   rmq_div_type   dv_ff [DW];
   rmq_div_type   dv_in [DW];
   logic          rsp_valid_ff;
   rmq_rsp_type   rsp_ff, rsp_in;

   // The whole pipe holds while a finished item waits to be taken.
   assign en          = !(rsp_valid_ff && rsp_stall);
   assign pop         = en && item_valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Load the root stage from the queue head.
   always_comb begin
      sq_in[0].v     = SQW'(item_data.rad) << FW;
      sq_in[0].res   = '0;
      sq_in[0].d_a   = item_data.d_a;
      sq_in[0].d_b   = item_data.d_b;
      sq_in[0].d_c   = item_data.d_c;
      sq_in[0].diag  = item_data.diag;
      sq_in[0].degen = item_data.degen;
   end

   // One result bit of the integer square root per stage.
   for (genvar t = 0; t < DW; t++) begin : g_sqrt
      localparam logic [SQW-1:0] SQ_BIT = SQW'(1) << (2 * (DW - 1 - t));
      logic [SQW-1:0] trial;
      always_comb begin
         trial      = sq_ff[t].res + SQ_BIT;
         sq_in[t+1] = sq_ff[t];
         if (sq_ff[t].v >= trial) begin
            sq_in[t+1].v   = sq_ff[t].v - trial;
            sq_in[t+1].res = (sq_ff[t].res >> 1) + SQ_BIT;
         end else begin
            sq_in[t+1].res = sq_ff[t].res >> 1;
         end
      end
   end

   // Divider set-up: numerators, divisor, overflow and the diagonal part.
   always_comb begin
      logic [DW-1:0]        s;
      logic [DW:0]          half;
      logic signed [DDW-1:0] d [3];
      logic [DDW-1:0]       mag;
      s    = sq_ff[DW].res[DW-1:0];
      half = ({1'b0, s} + 1'b1) >> 1;
      d[0] = sq_ff[DW].d_a;
      d[1] = sq_ff[DW].d_b;
      d[2] = sq_ff[DW].d_c;
      dv_in[0].den   = NW'(s) << 1;
      dv_in[0].q     = '0;
      dv_in[0].diag  = sq_ff[DW].diag;
      dv_in[0].degen = sq_ff[DW].degen;
      if (half[DW:DW-1] != 2'b00) begin
         dv_in[0].diag_val = VAL_MAX;
      end else begin
         dv_in[0].diag_val = half[DW-1:0];
      end
      for (int l = 0; l < 3; l++) begin
         dv_in[0].neg[l] = d[l][DDW-1];
         mag = d[l][DDW-1] ? DDW'(-d[l]) : DDW'(d[l]);
         dv_in[0].rem[l] = (NW'(mag) << FW) + NW'(s);
         dv_in[0].ovf[l] = dv_in[0].rem[l] >= (dv_in[0].den << (DW - 1));
      end
   end

   // One quotient bit per stage in each of the three lanes.
   for (genvar t = 0; t < DW - 1; t++) begin : g_div
      localparam int B = DW - 2 - t;
      logic [NW-1:0] shifted;
      always_comb begin
         shifted    = dv_ff[t].den << B;
         dv_in[t+1] = dv_ff[t];
         for (int l = 0; l < 3; l++) begin
            if (dv_ff[t].rem[l] >= shifted) begin
               dv_in[t+1].rem[l]  = dv_ff[t].rem[l] - shifted;
               dv_in[t+1].q[l][B] = 1'b1;
            end
         end
      end
   end

   // Sign, saturation and placement of the parts.
   always_comb begin
      logic signed [DW-1:0] part [3];
      rmq_div_type          f;
      f = dv_ff[DW-1];
      for (int l = 0; l < 3; l++) begin
         if (f.ovf[l]) begin
            part[l] = f.neg[l] ? VAL_MIN : VAL_MAX;
         end else if (f.neg[l]) begin
            part[l] = -{1'b0, f.q[l]};
         end else begin
            part[l] = {1'b0, f.q[l]};
         end
      end
      rsp_in.degenerate = f.degen;
      unique case (f.diag)
         SLOT_X: begin
            rsp_in.quat_x = f.diag_val;
            rsp_in.quat_y = part[0];
            rsp_in.quat_z = part[1];
            rsp_in.quat_w = part[2];
         end
         SLOT_Y: begin
            rsp_in.quat_x = part[0];
            rsp_in.quat_y = f.diag_val;
            rsp_in.quat_z = part[1];
            rsp_in.quat_w = part[2];
         end
         SLOT_Z: begin
            rsp_in.quat_x = part[0];
            rsp_in.quat_y = part[1];
            rsp_in.quat_z = f.diag_val;
            rsp_in.quat_w = part[2];
         end
         default: begin
            rsp_in.quat_x = part[0];
            rsp_in.quat_y = part[1];
            rsp_in.quat_z = part[2];
            rsp_in.quat_w = f.diag_val;
         end
      endcase
   end

   // Valid bits of the pipe.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= '0;
         dv_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff  <= {sq_valid_ff[DW-1:0], item_valid};
         dv_valid_ff  <= {dv_valid_ff[DW-2:0], sq_valid_ff[DW]};
         rsp_valid_ff <= dv_valid_ff[DW-1];
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int t = 0; t <= DW; t++) begin
            sq_ff[t] <= sq_in[t];
         end
         for (int t = 0; t < DW; t++) begin
            dv_ff[t] <= dv_in[t];
         end
         rsp_ff <= rsp_in;
      end
   end

   `RMQ_ASSERT(a_hold_pipe, !en |=> $stable(sq_valid_ff) && $stable(dv_valid_ff))
endmodule
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter.
// Throughput: one matrix per cycle while the result output is not stalled.
// The root and divider stages are fully pipelined.
// A stalled result holds the whole back pipe; a four-item queue decouples the front.
// Reset is synchronous and clears only valid bits, queue pointers and counts.
`default_nettype none
module rotation_matrix_to_quaternion (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire rmq_pkg::rmq_req_type req_payload,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      rmq_pkg::rmq_rsp_type rsp_payload
);
   import rmq_pkg::*;

   logic         task_valid, task_full, q_empty, q_pop;
   rmq_task_type task_data, head_data;

   rmq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .task_valid  (task_valid),
      .task_data   (task_data),
      .task_full   (task_full)
   );

   rmq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (task_valid),
      .push_data  (task_data),
      .full       (task_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head_data  (head_data)
   );

   rmq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (!q_empty),
      .item_data   (head_data),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the rotation matrix to quaternion converter: directed and random matrices.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import rmq_pkg::*;

   localparam int FB = DW - 2;
   localparam longint ONE = longint'(1) << FB;
   localparam longint QMAX = (longint'(1) << (DW - 1)) - 1;
   localparam longint QMIN = -(longint'(1) << (DW - 1));

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   rmq_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rmq_rsp_type rsp_payload;

   rmq_rsp_type quat_queue[$];
   int          errors;
   int          send_idle_pct;
   int          stall_pct;

   rotation_matrix_to_quaternion dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   // Clock generation; the first rising edge comes half a period in.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Integer square root of a non-negative value.
   function automatic longint int_sqrt(longint v);
      longint res;
      longint b;
      res = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >>> 1) + b;
         end else begin
            res = res >>> 1;
         end
         b = b >>> 2;
      end
      return res;
   endfunction

   function automatic longint clip(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   // Off-diagonal part: d * 2^F / (2s), rounded half away from zero, saturated.
   function automatic longint off_part(longint d, longint s);
      longint mag;
      longint den;
      longint q;
      mag = (d < 0) ? -d : d;
      den = s * 2;
      q = ((mag << FB) + (den >>> 1)) / den;
      if (q > (longint'(1) << DW)) q = longint'(1) << DW;
      return clip((d < 0) ? -q : q);
   endfunction

   // Shepperd conversion of one matrix into the expected quaternion.
   function automatic rmq_rsp_type shepperd(rmq_req_type mx);
      longint m[3][3];
      longint q[4];
      longint tr;
      longint rad;
      longint s;
      logic   dg;
      int     i;
      int     j;
      int     k;
      rmq_rsp_type r;
      m[0][0] = mx.m00; m[0][1] = mx.m01; m[0][2] = mx.m02;
      m[1][0] = mx.m10; m[1][1] = mx.m11; m[1][2] = mx.m12;
      m[2][0] = mx.m20; m[2][1] = mx.m21; m[2][2] = mx.m22;
      dg = 1'b0;
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         rad = tr + ONE;
         if (rad <= 0) begin
            rad = 1;
            dg = 1'b1;
         end
         s = int_sqrt(rad << FB);
         q[3] = clip((s + 1) >>> 1);
         q[0] = off_part(m[2][1] - m[1][2], s);
         q[1] = off_part(m[0][2] - m[2][0], s);
         q[2] = off_part(m[1][0] - m[0][1], s);
      end else begin
         if (m[0][0] < m[1][1]) i = (m[1][1] < m[2][2]) ? 2 : 1;
         else i = (m[0][0] < m[2][2]) ? 2 : 0;
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         rad = m[i][i] - m[j][j] - m[k][k] + ONE;
         if (rad <= 0) begin
            rad = 1;
            dg = 1'b1;
         end
         s = int_sqrt(rad << FB);
         q[i] = clip((s + 1) >>> 1);
         q[3] = off_part(m[k][j] - m[j][k], s);
         q[j] = off_part(m[j][i] + m[i][j], s);
         q[k] = off_part(m[k][i] + m[i][k], s);
      end
      r.quat_x = q[0][DW-1:0];
      r.quat_y = q[1][DW-1:0];
      r.quat_z = q[2][DW-1:0];
      r.quat_w = q[3][DW-1:0];
      r.degenerate = dg;
      return r;
   endfunction

   // Offer one matrix, with random idle cycles before it, and wait for acceptance.
   // Valid stays high after acceptance so that items can follow back to back.
   task automatic send_matrix(rmq_req_type mx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= mx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      quat_queue = {quat_queue, shepperd(mx)};
   endtask

   function automatic rmq_req_type mk(longint a, longint b, longint c, longint d,
                                      longint e, longint f, longint g, longint h,
                                      longint n);
      rmq_req_type mx;
      mx.m00 = DW'(a); mx.m01 = DW'(b); mx.m02 = DW'(c);
      mx.m10 = DW'(d); mx.m11 = DW'(e); mx.m12 = DW'(f);
      mx.m20 = DW'(g); mx.m21 = DW'(h); mx.m22 = DW'(n);
      return mx;
   endfunction

   // Uniform value between minus one and one.
   function automatic longint rnd_unit();
      return longint'($urandom_range(int'(2 * ONE))) - ONE;
   endfunction

   // Random entry: mostly within the rotation range, sometimes anywhere.
   function automatic longint rnd_entry();
      if ($urandom_range(3) == 0) return longint'($urandom_range(int'(QMAX - QMIN))) + QMIN;
      return rnd_unit();
   endfunction

   // Random rotation-like matrix built from a random quaternion (fixed point).
   function automatic rmq_req_type rnd_rotation();
      longint a;
      longint b;
      longint c;
      longint d;
      longint n;
      longint o;
      do begin
         a = rnd_unit();
         b = rnd_unit();
         c = rnd_unit();
         d = rnd_unit();
         n = (a * a + b * b + c * c + d * d) >>> FB;
      end while (n < ONE / 4);
      o = ONE;
      return mk(clip(o - 2 * ((b * b + c * c) * o / n) / o),
                clip(2 * ((a * b - c * d) * o / n) / o),
                clip(2 * ((a * c + b * d) * o / n) / o),
                clip(2 * ((a * b + c * d) * o / n) / o),
                clip(o - 2 * ((a * a + c * c) * o / n) / o),
                clip(2 * ((b * c - a * d) * o / n) / o),
                clip(2 * ((a * c - b * d) * o / n) / o),
                clip(2 * ((b * c + a * d) * o / n) / o),
                clip(o - 2 * ((a * a + b * b) * o / n) / o));
   endfunction

   // Compare each accepted result with the oldest expected quaternion.
   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (quat_queue.size() == 0) begin
               $error("unexpected quaternion %h", rsp_payload);
               errors++;
            end else begin
               rmq_rsp_type e;
               e = quat_queue.pop_front();
               if (rsp_payload.quat_x !== e.quat_x) begin
                  $error("quat_x expected %0d got %0d", e.quat_x, rsp_payload.quat_x);
                  errors++;
               end
               if (rsp_payload.quat_y !== e.quat_y) begin
                  $error("quat_y expected %0d got %0d", e.quat_y, rsp_payload.quat_y);
                  errors++;
               end
               if (rsp_payload.quat_z !== e.quat_z) begin
                  $error("quat_z expected %0d got %0d", e.quat_z, rsp_payload.quat_z);
                  errors++;
               end
               if (rsp_payload.quat_w !== e.quat_w) begin
                  $error("quat_w expected %0d got %0d", e.quat_w, rsp_payload.quat_w);
                  errors++;
               end
               if (rsp_payload.degenerate !== e.degenerate) begin
                  $error("degenerate expected %0b got %0b", e.degenerate,
                         rsp_payload.degenerate);
                  errors++;
               end
            end
         end
      end
   end

   // Identity, half-turns, trace zero, diagonal ties, extremes and non-rotations.
   task automatic test_directed();
      longint o;
      o = ONE;
      send_matrix(mk(o, 0, 0, 0, o, 0, 0, 0, o));
      send_matrix(mk(o, 0, 0, 0, -o, 0, 0, 0, -o));
      send_matrix(mk(-o, 0, 0, 0, o, 0, 0, 0, -o));
      send_matrix(mk(-o, 0, 0, 0, -o, 0, 0, 0, o));
      send_matrix(mk(0, -o, 0, o, 0, 0, 0, 0, o));
      send_matrix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_matrix(mk(o, 0, 0, 0, 0, 0, 0, 0, -o));
      send_matrix(mk(-o, 0, 0, 0, -o, 0, 0, 0, -o));
      send_matrix(mk(-o / 3, 0, 0, 0, -o / 3, 0, 0, 0, -o / 3));
      send_matrix(mk(-o, 5, 7, 9, -o, 11, 13, 15, 0));
      send_matrix(mk(0, 1, 2, 3, -o, 4, 5, 6, 0));
      send_matrix(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                     -32768));
      send_matrix(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_matrix(mk(32767, -32768, 32767, -32768, -32768, 32767, 32767, -32768, -32768));
      send_matrix(mk(-32768, 32767, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
      send_matrix(mk(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767));
      send_matrix(mk(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0));
      send_matrix(mk(-1, 32767, 32767, 32767, -1, 32767, 32767, 32767, 1));
      send_matrix(mk(-32768, 100, -100, 100, -32768, 100, -100, 100, -32768));
   endtask

   task automatic test_random(int count);
      repeat (count) begin
         if ($urandom_range(9) < 6) send_matrix(rnd_rotation());
         else send_matrix(mk(rnd_entry(), rnd_entry(), rnd_entry(), rnd_entry(),
                             rnd_entry(), rnd_entry(), rnd_entry(), rnd_entry(),
                             rnd_entry()));
      end
   endtask

   initial begin
      errors = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      rsp_stall <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      send_idle_pct = 63;
      test_random(200);
      send_idle_pct = 0;
      stall_pct = 63;
      test_random(200);
      send_idle_pct = 30;
      stall_pct = 30;
      test_random(200);
      req_valid <= 1'b0;
      while (quat_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
